### src/masked_selective_event_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked selective event queue
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_SELECTIVE_EVENT_QUEUE_TOP_ASSERT_SVH
`define MASKED_SELECTIVE_EVENT_QUEUE_TOP_ASSERT_SVH

// property must hold at every edge out of reset
`define MSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen out of reset
`define MSEQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### src/mseq_pkg.sv
// ----------------------------------------------------------------------------
// mseq_pkg
// Types and constants shared by the event queue controller and cells.
// ----------------------------------------------------------------------------
package mseq_pkg;

  localparam int unsigned DEPTH_DEF = 8;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned BIND_W    = 32;
  localparam int unsigned TYPE_W    = 6;
  localparam int unsigned PAY_W     = 64;
  localparam int unsigned ENTRY_W   = BIND_W + TYPE_W + PAY_W;
  localparam int unsigned TDATA_W   = ((ENTRY_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ   = 3'd0,
    KIND_DEQ   = 3'd1,
    KIND_FIND  = 3'd2,
    KIND_PEND  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef struct packed {
    logic [PAY_W-1:0]  payload;
    logic [TYPE_W-1:0] etype;
    logic [BIND_W-1:0] binding;
  } entry_t;

  // search token walking down the cell row
  typedef struct packed {
    logic   active;
    logic   found;
    entry_t entry;
  } token_t;

  // broadcast from controller to every cell
  typedef struct packed {
    logic              enq;
    logic              clr;
    logic              compact;
    logic              want_type;
    logic [BIND_W-1:0] mask;
    logic [TYPE_W-1:0] etype;
  } cmd_t;

  typedef struct packed {
    status_e status;
    entry_t  entry;
  } result_t;

endpackage

### src/mseq_cell.sv
// ----------------------------------------------------------------------------
// mseq_cell
// One queue slot: holds an entry, checks the passing search token and
// shifts down from its younger neighbor when a dequeue closes the gap.
// ----------------------------------------------------------------------------
module mseq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mseq_pkg::cmd_t   cmd_i,
  input  mseq_pkg::entry_t enq_entry_i,
  input  logic            prev_valid_i,
  input  logic            next_valid_i,
  input  mseq_pkg::entry_t next_entry_i,
  input  mseq_pkg::token_t tok_i,
  output mseq_pkg::token_t tok_o,
  output logic            valid_o,
  output mseq_pkg::entry_t entry_o
);
  import mseq_pkg::*;

  `include "masked_selective_event_queue_top_assert.svh"

  logic   valid_q, valid_d;
  logic   rm_q, rm_d;
  entry_t entry_q, entry_d;
  token_t tok_q, tok_d;
  logic   hit;

  assign hit = valid_q && ((entry_q.binding & cmd_i.mask) != '0) &&
               (!cmd_i.want_type || (entry_q.etype == cmd_i.etype));

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.clr) begin
      valid_d = 1'b0;
    end else if (cmd_i.enq && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      entry_d = enq_entry_i;
    end else if (cmd_i.compact && rm_q) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end
  end

  // this slot and every younger one shift when the first hit is at or before it
  always_comb begin
    rm_d = rm_q;
    if (tok_i.active) begin
      rm_d = tok_i.found || hit;
    end else if (cmd_i.compact) begin
      rm_d = 1'b0;
    end
  end

  always_comb begin
    tok_d        = tok_i;
    tok_d.found  = tok_i.active && (tok_i.found || hit);
    if (tok_i.active && !tok_i.found && hit) begin
      tok_d.entry = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rm_q    <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rm_q    <= rm_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

  `MSEQ_ASSERT_NEVER(a_contig, next_valid_i && !valid_q, "younger slot valid behind a hole")
  `MSEQ_ASSERT(a_fill_src, $rose(valid_q) |-> $past(cmd_i.enq || cmd_i.compact), "slot filled without enqueue or shift")
  `MSEQ_ASSERT(a_found_kept, tok_i.active && tok_i.found |=> tok_q.found, "search token lost its hit")

endmodule

### src/mseq_ctrl.sv
// ----------------------------------------------------------------------------
// mseq_ctrl
// Operation sequencer: decodes the request, launches the search token,
// collects the answer and holds it in the output register.
// ----------------------------------------------------------------------------
module mseq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [mseq_pkg::KIND_W-1:0]   kind_i,
  input  mseq_pkg::entry_t              in_entry_i,
  input  logic                          last_valid_i,
  input  mseq_pkg::token_t              last_tok_i,
  output mseq_pkg::cmd_t                cmd_o,
  output logic                          start_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output mseq_pkg::result_t             res_o
);
  import mseq_pkg::*;

  `include "masked_selective_event_queue_top_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_e;

  state_e            state_q, state_d;
  kind_e             kind_q, kind_d, kind_in;
  logic [BIND_W-1:0] mask_q, mask_d;
  logic [TYPE_W-1:0] etype_q, etype_d;
  logic              start_q, start_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;
  result_t           new_res;
  logic              have_res;
  logic              out_free;
  logic              accept;

  assign kind_in  = kind_e'(kind_i);
  assign accept   = s_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    mask_d      = mask_q;
    etype_d     = etype_q;
    start_d     = 1'b0;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_ready_i;
    have_res    = 1'b0;
    new_res     = '0;

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          case (kind_in)
            KIND_DEQ, KIND_FIND, KIND_PEND: begin
              kind_d  = kind_in;
              mask_d  = in_entry_i.binding;
              etype_d = in_entry_i.etype;
              start_d = 1'b1;
              state_d = S_SCAN;
            end
            KIND_ENQ: begin
              have_res       = 1'b1;
              new_res.status = last_valid_i ? ST_FULL : ST_OK;
            end
            default: begin
              have_res = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (last_tok_i.active) begin
          have_res       = 1'b1;
          new_res.status = last_tok_i.found ? ST_OK : ST_NONE;
          if (last_tok_i.found && (kind_q != KIND_PEND)) begin
            new_res.entry = last_tok_i.entry;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (have_res) begin
      if (out_free) begin
        out_d       = new_res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = new_res;
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KIND_ENQ;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    etype_q <= etype_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.enq       = accept && (kind_in == KIND_ENQ) && !last_valid_i;
    cmd_o.clr       = accept && (kind_in == KIND_CLEAR);
    cmd_o.compact   = (state_q == S_SCAN) && last_tok_i.active && last_tok_i.found &&
                      (kind_q == KIND_DEQ);
    cmd_o.want_type = (kind_q == KIND_FIND);
    cmd_o.mask      = mask_q;
    cmd_o.etype     = etype_q;
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign start_o   = start_q;
  assign m_valid_o = out_valid_q;
  assign res_o     = out_q;

  `MSEQ_ASSERT(a_hold_full, state_q == S_HOLD |-> out_valid_q, "result held with empty output register")
  `MSEQ_ASSERT(a_tok_scan, last_tok_i.active |-> state_q == S_SCAN, "search token ended outside a scan")
  `MSEQ_ASSERT(a_compact_deq, cmd_o.compact |-> kind_q == KIND_DEQ, "slot shift on a non-dequeue")

endmodule

### src/masked_selective_event_queue_top.sv
// ----------------------------------------------------------------------------
// masked_selective_event_queue_top
// Ordered event queue with masked selective dequeue, find and pending query.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on the s_axis channel: tuser carries the operation
//    (enqueue, dequeue, find, pending, clear; other codes are a no-op),
//    tdata the binding mask, event type and payload.
//  - Each request produces exactly one transfer on m_axis: tuser is the
//    status (done/found, full, no match), tdata the returned entry or zero.
//  - The queue holds at most DEPTH-2 entries in a row of DEPTH-2 cells,
//    oldest first; an enqueue into a full row answers full.
//  - Enqueue, clear and no-op are answered without a search.
//  - Dequeue, find and pending send a search token down the cell row, one
//    cell per cycle: a dequeue closes the gap in the row when the token
//    leaves the last cell, where the answer is taken.
//  - One request is in work at a time; s_axis_tready is high whenever no
//    request is in work, including while an answer waits in the output
//    register. If the answer is stalled and a second one is ready, it is
//    parked and s_axis_tready drops until m_axis takes the first.
//  - Reset empties the queue and the output register; entry contents are
//    not cleared, only their valid bits.
// ----------------------------------------------------------------------------
module masked_selective_event_queue_top #(
  parameter int unsigned DEPTH = mseq_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] binding_mask, [37:32] event_type, [101:38] event_payload, [103:102] zero
  input  logic [mseq_pkg::TDATA_W-1:0]   s_axis_tdata_i,
  // [2:0] kind
  input  logic [mseq_pkg::KIND_W-1:0]    s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] out_binding, [37:32] out_type, [101:38] out_payload, [103:102] zero
  output logic [mseq_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  // [1:0] status
  output logic [mseq_pkg::STATUS_W-1:0]  m_axis_tuser_o
);
  import mseq_pkg::*;

  localparam int unsigned NCELL = DEPTH - 2;

  entry_t     in_entry;
  cmd_t       cmd;
  logic       start;
  result_t    res;
  token_t     tok_w   [NCELL+1];
  entry_t     ent_w   [NCELL+1];
  logic [NCELL:0] valid_w;

  // unpack request payload, low field first
  assign in_entry.binding = s_axis_tdata_i[BIND_W-1:0];
  assign in_entry.etype   = s_axis_tdata_i[BIND_W+TYPE_W-1:BIND_W];
  assign in_entry.payload = s_axis_tdata_i[ENTRY_W-1:BIND_W+TYPE_W];

  // token enters the oldest cell; padding slot past the youngest is empty
  assign tok_w[0]       = '{active: start, found: 1'b0, entry: '0};
  assign valid_w[NCELL] = 1'b0;
  assign ent_w[NCELL]   = '0;

  mseq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .kind_i       (s_axis_tuser_i),
    .in_entry_i   (in_entry),
    .last_valid_i (valid_w[NCELL-1]),
    .last_tok_i   (tok_w[NCELL]),
    .cmd_o        (cmd),
    .start_o      (start),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .res_o        (res)
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_w[i-1];
    end

    mseq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .enq_entry_i  (in_entry),
      .prev_valid_i (prev_valid),
      .next_valid_i (valid_w[i+1]),
      .next_entry_i (ent_w[i+1]),
      .tok_i        (tok_w[i]),
      .tok_o        (tok_w[i+1]),
      .valid_o      (valid_w[i]),
      .entry_o      (ent_w[i])
    );
  end

  assign m_axis_tdata_o = {{(TDATA_W-ENTRY_W){1'b0}},
                           res.entry.payload, res.entry.etype, res.entry.binding};
  assign m_axis_tuser_o = res.status;

endmodule
